@@ rtl/joystick_axis_calibrate_map_defines.svh @@
// Assertion macros shared by the joystick calibration RTL.
`ifndef JOYSTICK_AXIS_CALIBRATE_MAP_DEFINES_SVH
`define JOYSTICK_AXIS_CALIBRATE_MAP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define JACM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define JACM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jacm_pkg.sv @@
package jacm_pkg;

    localparam int ADC_BITS_DFLT = 10;
    localparam int OUT_BITS_DFLT = 8;
    localparam int LOAD_BITS     = 16;
    localparam int CMD_BITS      = 2;
    localparam int CFG_IDX_BITS  = 3;

    localparam int CAL_ADC_MIN = 0;
    localparam int CAL_ADC_MID = 512;
    localparam int CAL_ADC_MAX = 1023;
    localparam int CAL_OUT_MIN = 0;
    localparam int CAL_OUT_MID = 128;
    localparam int CAL_OUT_MAX = 255;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CONVERT = 2'd0,
        CMD_TRACK   = 2'd1,
        CMD_CENTER  = 2'd2,
        CMD_LOAD    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VALID_LOW   = 3'd0,
        REG_VALID_HIGH  = 3'd1,
        REG_DEFAULT_MID = 3'd2,
        REG_OUT_MIN     = 3'd3,
        REG_OUT_MID     = 3'd4,
        REG_OUT_MAX     = 3'd5
    } t_reg;

    // Calibration update request from the sequencer.
    typedef struct packed {
        logic en;
        t_cmd cmd;
        logic axis;
    } t_cal_upd;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic last;
    } t_div_stat;

endpackage

@@ rtl/jacm_cal.sv @@
`include "joystick_axis_calibrate_map_defines.svh"

module jacm_cal
    import jacm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cal_upd             i_upd,
    input  logic [ADC_BITS-1:0]  i_x_sample,
    input  logic [ADC_BITS-1:0]  i_y_sample,
    input  logic [LOAD_BITS-1:0] i_load_min,
    input  logic [LOAD_BITS-1:0] i_load_mid,
    input  logic [LOAD_BITS-1:0] i_load_max,
    input  logic [ADC_BITS-1:0]  i_valid_low,
    input  logic [ADC_BITS-1:0]  i_valid_high,
    input  logic [ADC_BITS-1:0]  i_default_mid,
    output logic [ADC_BITS-1:0]  o_min    [2],
    output logic [ADC_BITS-1:0]  o_center [2],
    output logic [ADC_BITS-1:0]  o_max    [2]
);

    logic [ADC_BITS-1:0]  r_min [2];
    logic [ADC_BITS-1:0]  r_ctr [2];
    logic [ADC_BITS-1:0]  r_max [2];
    logic [ADC_BITS-1:0]  smp   [2];
    logic [LOAD_BITS-1:0] lo_ext;
    logic [LOAD_BITS-1:0] hi_ext;
    logic                 min_ok;
    logic                 mid_ok;
    logic                 max_ok;

    assign smp[0] = i_x_sample;
    assign smp[1] = i_y_sample;

    // Saved values are checked at their full stored width.
    assign lo_ext = LOAD_BITS'(i_valid_low);
    assign hi_ext = LOAD_BITS'(i_valid_high);
    assign min_ok = (i_load_min >= lo_ext) && (i_load_min <= hi_ext);
    assign mid_ok = (i_load_mid >= lo_ext) && (i_load_mid <= hi_ext);
    assign max_ok = (i_load_max >= lo_ext) && (i_load_max <= hi_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                r_min[a] <= ADC_BITS'(CAL_ADC_MID);
                r_ctr[a] <= ADC_BITS'(CAL_ADC_MID);
                r_max[a] <= ADC_BITS'(CAL_ADC_MID);
            end
        end else if (i_upd.en) begin
            for (int a = 0; a < 2; a++) begin
                unique case (i_upd.cmd)
                    CMD_CONVERT: begin
                    end
                    CMD_TRACK: begin
                        if (smp[a] >= r_max[a]) begin
                            r_max[a] <= smp[a];
                        end
                        if (smp[a] <= r_min[a]) begin
                            r_min[a] <= smp[a];
                        end
                    end
                    CMD_CENTER: begin
                        r_ctr[a] <= smp[a];
                    end
                    CMD_LOAD: begin
                        if (i_upd.axis == a[0]) begin
                            r_min[a] <= min_ok ? i_load_min[ADC_BITS-1:0] : i_valid_low;
                            r_ctr[a] <= mid_ok ? i_load_mid[ADC_BITS-1:0] : i_default_mid;
                            r_max[a] <= max_ok ? i_load_max[ADC_BITS-1:0] : i_valid_high;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_min    = r_min;
    assign o_center = r_ctr;
    assign o_max    = r_max;

endmodule

@@ rtl/jacm_div.sv @@
`include "joystick_axis_calibrate_map_defines.svh"

module jacm_div
    import jacm_pkg::*;
#(
    parameter int DVD_W = 19,
    parameter int DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);

    // Restoring division, two quotient bits per cycle.
    localparam int STEPS = (DVD_W + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [QW-1:0]    r_quo;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;

    logic [DVS_W:0] rem1;
    logic [DVS_W:0] rem1_red;
    logic [DVS_W:0] rem2;
    logic [DVS_W:0] rem2_red;
    logic           q1;
    logic           q2;

    always_comb begin
        rem1     = {r_rem[DVS_W-1:0], r_quo[QW-1]};
        q1       = rem1 >= {1'b0, r_dvs};
        rem1_red = q1 ? (rem1 - {1'b0, r_dvs}) : rem1;
        rem2     = {rem1_red[DVS_W-1:0], r_quo[QW-2]};
        q2       = rem2 >= {1'b0, r_dvs};
        rem2_red = q2 ? (rem2 - {1'b0, r_dvs}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[QW-3:0], q1, q2};
            r_rem <= rem2_red;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.last = (r_cnt == CNT_W'(1));
    assign o_quotient  = r_quo[DVD_W-1:0];

    `JACM_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, i_start, r_cnt == '0, "divider restarted while busy")
    `JACM_ASSERT_NEXT(a_div_loads_count, i_clk, i_rst_n, i_start, r_cnt == CNT_W'(STEPS), "divider count not loaded")
    `JACM_ASSERT_IMP(a_div_nonzero_divisor, i_clk, i_rst_n, i_start, i_divisor != '0, "divide by a zero span")

endmodule

@@ rtl/joystick_axis_calibrate_map.sv @@
// An accepted request goes through the calibration update and then, for each axis,
// through setup, two multiplies, a sign split and the serial divide; an axis whose
// half is empty skips the multiplies, sign split and divide. A new request is not taken
// until the sequencer is back in idle, once the result has entered the output register.
// Reset (synchronous, active low) restores the configuration registers and the
// calibration to their defaults and empties the result register.
`include "joystick_axis_calibrate_map_defines.svh"

module joystick_axis_calibrate_map
    import jacm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DFLT,
    parameter int OUT_BITS = OUT_BITS_DFLT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [((ADC_BITS > OUT_BITS) ? ADC_BITS : OUT_BITS)-1:0] i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_BITS-1:0]     i_cmd,
    input  logic [ADC_BITS-1:0]     i_x_sample,
    input  logic [ADC_BITS-1:0]     i_y_sample,
    input  logic                    i_button_a,
    input  logic                    i_button_b,
    input  logic                    i_load_axis,
    input  logic [LOAD_BITS-1:0]    i_load_min,
    input  logic [LOAD_BITS-1:0]    i_load_mid,
    input  logic [LOAD_BITS-1:0]    i_load_max,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_BITS-1:0]     o_x_out,
    output logic [OUT_BITS-1:0]     o_y_out,
    output logic                    o_button_a_out,
    output logic                    o_button_b_out
);

    // The mapping numerator is start_out * span + delta_out * offset. Its magnitude
    // stays below 2^(ADC_BITS + OUT_BITS + 1), so one sign bit on top is enough.
    localparam int NUM_W = ADC_BITS + OUT_BITS + 2;
    localparam int MAG_W = ADC_BITS + OUT_BITS + 1;

    // The sequencer walks one axis at a time through setup, two multiplies into a shared
    // accumulator, a sign split and the serial divide (all but setup skipped for an empty
    // half) and finishes the axis. After both axes the result goes to the output register.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_UPDATE = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_MUL_A  = 9'b000001000,
        ST_MUL_B  = 9'b000010000,
        ST_SIGN   = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_FIN    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [ADC_BITS-1:0] r_valid_low;
    logic [ADC_BITS-1:0] r_valid_high;
    logic [ADC_BITS-1:0] r_default_mid;
    logic [OUT_BITS-1:0] r_out_min;
    logic [OUT_BITS-1:0] r_out_mid;
    logic [OUT_BITS-1:0] r_out_max;

    // The accepted request.
    t_cmd                 r_cmd;
    logic [ADC_BITS-1:0]  r_x;
    logic [ADC_BITS-1:0]  r_y;
    logic                 r_btn_a;
    logic                 r_btn_b;
    logic                 r_load_axis;
    logic [LOAD_BITS-1:0] r_load_min;
    logic [LOAD_BITS-1:0] r_load_mid;
    logic [LOAD_BITS-1:0] r_load_max;

    // Per-axis working registers. The offset from the half's start is signed:
    // with a min above the max the clamped sample can sit below the min.
    logic                 r_axis;
    logic [ADC_BITS-1:0]  r_span;
    logic signed [ADC_BITS:0] r_d;
    logic [OUT_BITS-1:0]  r_ostart;
    logic [OUT_BITS+1:0]  r_delta;
    logic                 r_empty;
    logic                 r_neg;
    logic signed [NUM_W-1:0] r_num;
    logic [OUT_BITS-1:0]  r_map [2];

    // Result register.
    logic                 r_out_valid;
    logic [OUT_BITS-1:0]  r_x_out;
    logic [OUT_BITS-1:0]  r_y_out;
    logic                 r_btn_a_out;
    logic                 r_btn_b_out;

    logic in_acc;
    logic out_acc;
    logic out_free;

    t_cal_upd            cal_upd;
    logic [ADC_BITS-1:0] cal_min    [2];
    logic [ADC_BITS-1:0] cal_center [2];
    logic [ADC_BITS-1:0] cal_max    [2];

    t_div_stat           div_stat;
    logic                div_start;
    logic [MAG_W-1:0]    div_quo;
    logic [MAG_W-1:0]    num_mag;
    logic [NUM_W-1:0]    num_neg;

    logic [ADC_BITS-1:0] s_raw;
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] mid;
    logic [ADC_BITS-1:0] hi;
    logic [ADC_BITS-1:0] s_clamp;
    logic [ADC_BITS-1:0] in_start;
    logic                lower;
    logic [ADC_BITS+1:0] span;
    logic [OUT_BITS+1:0] delta;
    logic                empty;

    logic signed [OUT_BITS+1:0] mul_a;
    logic signed [ADC_BITS:0]   mul_b;
    logic signed [NUM_W-1:0]    prod;

    logic [OUT_BITS-1:0] q_low;
    logic [OUT_BITS-1:0] res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration port. Writes must land only while the block is idle; the
    // block itself does not enforce this. Writes take effect directly.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_low   <= ADC_BITS'(CAL_ADC_MIN);
            r_valid_high  <= ADC_BITS'(CAL_ADC_MAX);
            r_default_mid <= ADC_BITS'(CAL_ADC_MID);
            r_out_min     <= OUT_BITS'(CAL_OUT_MIN);
            r_out_mid     <= OUT_BITS'(CAL_OUT_MID);
            r_out_max     <= OUT_BITS'(CAL_OUT_MAX);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_VALID_LOW:   r_valid_low   <= i_cfg_data[ADC_BITS-1:0];
                REG_VALID_HIGH:  r_valid_high  <= i_cfg_data[ADC_BITS-1:0];
                REG_DEFAULT_MID: r_default_mid <= i_cfg_data[ADC_BITS-1:0];
                REG_OUT_MIN:     r_out_min     <= i_cfg_data[OUT_BITS-1:0];
                REG_OUT_MID:     r_out_mid     <= i_cfg_data[OUT_BITS-1:0];
                REG_OUT_MAX:     r_out_max     <= i_cfg_data[OUT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request capture.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_x         <= i_x_sample;
            r_y         <= i_y_sample;
            r_btn_a     <= i_button_a;
            r_btn_b     <= i_button_b;
            r_load_axis <= i_load_axis;
            r_load_min  <= i_load_min;
            r_load_mid  <= i_load_mid;
            r_load_max  <= i_load_max;
        end
    end

    // ------------------------------------------------------------------
    // Calibration store. It is updated once per request, in the update
    // state, so both axes are mapped with the calibration after the update.
    // ------------------------------------------------------------------
    assign cal_upd.en   = (r_state == ST_UPDATE);
    assign cal_upd.cmd  = r_cmd;
    assign cal_upd.axis = r_load_axis;

    jacm_cal #(
        .ADC_BITS(ADC_BITS)
    ) u_cal (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (cal_upd),
        .i_x_sample    (r_x),
        .i_y_sample    (r_y),
        .i_load_min    (r_load_min),
        .i_load_mid    (r_load_mid),
        .i_load_max    (r_load_max),
        .i_valid_low   (r_valid_low),
        .i_valid_high  (r_valid_high),
        .i_default_mid (r_default_mid),
        .o_min         (cal_min),
        .o_center      (cal_center),
        .o_max         (cal_max)
    );

    // ------------------------------------------------------------------
    // Setup for the current axis. The sample is clamped against the max
    // first and the min second, which settles the case of a min above
    // the max. The half is then chosen by comparing against the center.
    // Span and output delta are kept in two's complement one bit wider
    // than needed, so a negative span shows up in the top bit.
    // ------------------------------------------------------------------
    assign s_raw = r_axis ? r_y : r_x;
    assign lo    = cal_min[r_axis];
    assign mid   = cal_center[r_axis];
    assign hi    = cal_max[r_axis];

    always_comb begin
        priority if (s_raw > hi) begin
            s_clamp = hi;
        end else if (s_raw < lo) begin
            s_clamp = lo;
        end else begin
            s_clamp = s_raw;
        end
    end

    assign lower    = s_clamp < mid;
    assign in_start = lower ? lo : mid;
    assign span     = lower ? ({2'b00, mid} - {2'b00, lo} - (ADC_BITS+2)'(1))
                            : ({2'b00, hi} - {2'b00, mid});
    assign delta    = lower ? ({2'b00, r_out_mid} - {2'b00, r_out_min} - (OUT_BITS+2)'(1))
                            : ({2'b00, r_out_max} - {2'b00, r_out_mid});
    assign empty    = span[ADC_BITS+1] || (span == '0);

    // ------------------------------------------------------------------
    // One signed multiplier serves both products of the numerator: first
    // start_out * span, then delta_out * offset, accumulated into r_num.
    // ------------------------------------------------------------------
    assign mul_a = (r_state == ST_MUL_A) ? $signed({2'b00, r_ostart}) : $signed(r_delta);
    assign mul_b = (r_state == ST_MUL_A) ? $signed({1'b0, r_span}) : r_d;
    assign prod  = NUM_W'(mul_a) * NUM_W'(mul_b);

    // The divider works on the magnitude; the sign is put back afterwards,
    // which truncates the quotient toward zero.
    assign num_neg   = -r_num;
    assign num_mag   = r_num[NUM_W-1] ? num_neg[MAG_W-1:0] : r_num[MAG_W-1:0];
    assign div_start = (r_state == ST_SIGN);

    jacm_div #(
        .DVD_W(MAG_W),
        .DVS_W(ADC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  (r_span),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Only the low output bits of the quotient matter, and negation commutes
    // with that truncation. The axis value is then inverted against out_max.
    assign q_low = r_empty ? r_ostart
                           : (r_neg ? (-div_quo[OUT_BITS-1:0]) : div_quo[OUT_BITS-1:0]);
    assign res   = r_out_max - q_low;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = empty ? ST_FIN : ST_MUL_A;
            end
            ST_MUL_A: begin
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                n_state = ST_SIGN;
            end
            ST_SIGN: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = r_axis ? ST_DONE : ST_SETUP;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN) begin
                r_axis <= ~r_axis;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SETUP: begin
                r_span   <= span[ADC_BITS-1:0];
                r_d      <= {1'b0, s_clamp} - {1'b0, in_start};
                r_ostart <= lower ? r_out_min : r_out_mid;
                r_delta  <= delta;
                r_empty  <= empty;
            end
            ST_MUL_A: begin
                r_num <= prod;
            end
            ST_MUL_B: begin
                r_num <= r_num + prod;
            end
            ST_SIGN: begin
                r_neg <= r_num[NUM_W-1];
            end
            ST_FIN: begin
                r_map[r_axis] <= res;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_x_out     <= r_map[0];
                    r_y_out     <= r_map[1];
                    r_btn_a_out <= r_btn_a;
                    r_btn_b_out <= r_btn_b;
                end
            end
            default: begin
            end
        endcase
    end

    // A new request is taken whenever the sequencer is idle, even while the
    // previous result still waits in the output register.
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_x_out        = r_x_out;
    assign o_y_out        = r_y_out;
    assign o_button_a_out = r_btn_a_out;
    assign o_button_b_out = r_btn_b_out;

    `JACM_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_DONE), "result offered outside the done state")
    `JACM_ASSERT_IMP(a_div_running, i_clk, i_rst_n, r_state == ST_DIV, div_stat.busy, "waiting on an idle divider")
    `JACM_ASSERT_IMP(a_fin_after_div, i_clk, i_rst_n, (r_state == ST_FIN) && !r_empty, $past(r_state == ST_DIV), "axis finished without a divide")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import jacm_pkg::*;

    localparam int ADC_W   = ADC_BITS_DFLT;
    localparam int OUT_W   = OUT_BITS_DFLT;
    localparam int CFG_W   = (ADC_W > OUT_W) ? ADC_W : OUT_W;
    localparam int ADC_TOP = (1 << ADC_W) - 1;

    // Even with the long output hold-off a correct run stays well under this
    // limit, so it only trips on a hang.
    localparam int LIMIT_CYCLES = 1000000;
    // Past this many mismatches we keep counting but stop printing.
    localparam int MAX_REPORTS  = 60;
    // Quiet time allowed at the end of the run.
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_CYCLES  = 400;

    // Idle patterns applied to the two handshakes.
    typedef enum int {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    // One joystick request as it appears on the input ports.
    typedef struct {
        t_cmd                 cmd;
        logic [ADC_W-1:0]     x;
        logic [ADC_W-1:0]     y;
        logic                 btn_a;
        logic                 btn_b;
        logic                 axis;
        logic [LOAD_BITS-1:0] lmin;
        logic [LOAD_BITS-1:0] lmid;
        logic [LOAD_BITS-1:0] lmax;
    } t_joy_req;

    // One mapped report as it appears on the output ports.
    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             btn_a;
        logic             btn_b;
    } t_joy_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = REG_VALID_LOW;
    logic [CFG_W-1:0]        i_cfg_data  = '0;

    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [CMD_BITS-1:0]  i_cmd       = CMD_CONVERT;
    logic [ADC_W-1:0]     i_x_sample  = '0;
    logic [ADC_W-1:0]     i_y_sample  = '0;
    logic                 i_button_a  = 1'b0;
    logic                 i_button_b  = 1'b0;
    logic                 i_load_axis = 1'b0;
    logic [LOAD_BITS-1:0] i_load_min  = '0;
    logic [LOAD_BITS-1:0] i_load_mid  = '0;
    logic [LOAD_BITS-1:0] i_load_max  = '0;

    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [OUT_W-1:0] o_x_out;
    logic [OUT_W-1:0] o_y_out;
    logic             o_button_a_out;
    logic             o_button_b_out;

    joystick_axis_calibrate_map uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_button_a     (i_button_a),
        .i_button_b     (i_button_b),
        .i_load_axis    (i_load_axis),
        .i_load_min     (i_load_min),
        .i_load_mid     (i_load_mid),
        .i_load_max     (i_load_max),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_button_a_out (o_button_a_out),
        .o_button_b_out (o_button_b_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file, kept in step with every write.
    logic [ADC_W-1:0] cfg_valid_low   = ADC_W'(CAL_ADC_MIN);
    logic [ADC_W-1:0] cfg_valid_high  = ADC_W'(CAL_ADC_MAX);
    logic [ADC_W-1:0] cfg_default_mid = ADC_W'(CAL_ADC_MID);
    logic [OUT_W-1:0] cfg_out_min     = OUT_W'(CAL_OUT_MIN);
    logic [OUT_W-1:0] cfg_out_mid     = OUT_W'(CAL_OUT_MID);
    logic [OUT_W-1:0] cfg_out_max     = OUT_W'(CAL_OUT_MAX);

    // Shadow calibration per axis (0 horizontal, 1 vertical); all start centered.
    logic [ADC_W-1:0] cal_min[2]    = '{ADC_W'(CAL_ADC_MID), ADC_W'(CAL_ADC_MID)};
    logic [ADC_W-1:0] cal_center[2] = '{ADC_W'(CAL_ADC_MID), ADC_W'(CAL_ADC_MID)};
    logic [ADC_W-1:0] cal_max[2]    = '{ADC_W'(CAL_ADC_MID), ADC_W'(CAL_ADC_MID)};

    t_joy_req req_q[$];        // requests waiting for the driver
    t_joy_res expected_xy[$];  // predicted reports, oldest first
    t_joy_req offered_req;     // request currently on the input ports

    int    reqs_queued    = 0;
    int    req_sent       = 0;
    int    req_accepted   = 0;
    int    results_seen   = 0;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    settings_run   = 0;
    int    cmd_count[4]   = '{0, 0, 0, 0};
    int    out_hold_cycles = 0;
    t_pace pace = PACE_FREE;

    function automatic bit chance(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic int sender_idle_pct();
        case (pace)
            PACE_SENDER: return 53;
            PACE_BOTH:   return 16;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (pace)
            PACE_RECEIVER: return 53;
            PACE_BOTH:     return 16;
            default:       return 0;
        endcase
    endfunction

    // Clamp the sample into [lo, hi] (max tested first, so with an inverted pair a
    // sample above hi ends at hi, any other at lo), pick the half around the center
    // and interpolate with a truncating divide. The axis report is that value
    // subtracted from out_max, wrapped to the output width.
    function automatic logic [OUT_W-1:0] map_to_report(logic [ADC_W-1:0] smp,
            logic [ADC_W-1:0] lo, logic [ADC_W-1:0] mid, logic [ADC_W-1:0] hi);
        longint s, lo_v, mid_v, hi_v;
        longint in_start, in_end, o_start, o_end, span, q;
        s     = longint'(smp);
        lo_v  = longint'(lo);
        mid_v = longint'(mid);
        hi_v  = longint'(hi);
        if (s > hi_v) begin
            s = hi_v;
        end else if (s < lo_v) begin
            s = lo_v;
        end
        if (s < mid_v) begin
            in_start = lo_v;
            in_end   = mid_v - 1;
            o_start  = longint'(cfg_out_min);
            o_end    = longint'(cfg_out_mid) - 1;
        end else begin
            in_start = mid_v;
            in_end   = hi_v;
            o_start  = longint'(cfg_out_mid);
            o_end    = longint'(cfg_out_max);
        end
        span = in_end - in_start;
        // An empty half pins the value to its start code. Otherwise the signed
        // divide truncates toward zero, which covers the odd settings where
        // the numerator goes negative.
        if (span <= 0) begin
            q = o_start;
        end else begin
            q = (o_start * span + (o_end - o_start) * (s - in_start)) / span;
        end
        return cfg_out_max - q[OUT_W-1:0];
    endfunction

    function automatic bit in_valid_window(logic [LOAD_BITS-1:0] v);
        return v >= LOAD_BITS'(cfg_valid_low) && v <= LOAD_BITS'(cfg_valid_high);
    endfunction

    // Apply the request's calibration update to the shadow state, then map
    // both axes with the updated calibration.
    function automatic t_joy_res calibrate_and_map(t_joy_req r);
        t_joy_res         res;
        logic [ADC_W-1:0] smp[2];
        smp[0] = r.x;
        smp[1] = r.y;
        case (r.cmd)
            CMD_TRACK: begin
                for (int i = 0; i < 2; i++) begin
                    if (smp[i] >= cal_max[i]) cal_max[i] = smp[i];
                    if (smp[i] <= cal_min[i]) cal_min[i] = smp[i];
                end
            end
            CMD_CENTER: begin
                cal_center[0] = smp[0];
                cal_center[1] = smp[1];
            end
            CMD_LOAD: begin
                // Anything outside the validity window falls back to a default.
                cal_min[r.axis]    = in_valid_window(r.lmin) ? r.lmin[ADC_W-1:0]
                                                             : cfg_valid_low;
                cal_center[r.axis] = in_valid_window(r.lmid) ? r.lmid[ADC_W-1:0]
                                                             : cfg_default_mid;
                cal_max[r.axis]    = in_valid_window(r.lmax) ? r.lmax[ADC_W-1:0]
                                                             : cfg_valid_high;
            end
            default: begin
            end
        endcase
        res.x     = map_to_report(smp[0], cal_min[0], cal_center[0], cal_max[0]);
        res.y     = map_to_report(smp[1], cal_min[1], cal_center[1], cal_max[1]);
        res.btn_a = r.btn_a;
        res.btn_b = r.btn_b;
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    // Request driver. A new request is considered only when the port is free,
    // i.e. nothing is offered or the last offer was taken at the previous
    // rising edge, so an offered request holds steady through any stall.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_accepted == req_sent) begin
                if (req_q.size() > 0 && !chance(sender_idle_pct())) begin
                    offered_req = req_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_cmd       <= offered_req.cmd;
                    i_x_sample  <= offered_req.x;
                    i_y_sample  <= offered_req.y;
                    i_button_a  <= offered_req.btn_a;
                    i_button_b  <= offered_req.btn_b;
                    i_load_axis <= offered_req.axis;
                    i_load_min  <= offered_req.lmin;
                    i_load_mid  <= offered_req.lmid;
                    i_load_max  <= offered_req.lmax;
                    req_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure. A forced hold-off takes priority over the random
    // stall pattern and is counted down here, one cycle at a time.
    always @(negedge i_clk) begin
        if (out_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            out_hold_cycles--;
        end else begin
            i_out_stall <= chance(receiver_stall_pct());
        end
    end

    // Monitor: the output side is checked before the input side so that a
    // report can never be matched against the request taken at the same edge.
    always @(posedge i_clk) begin : monitor
        t_joy_res want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles.", LIMIT_CYCLES);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_xy.size() == 0) begin
                    report_mismatch("unexpected report, x", 32'(o_x_out), 0);
                end else begin
                    want = expected_xy.pop_front();
                    if (o_x_out !== want.x) begin
                        report_mismatch("x_out", 32'(o_x_out), 32'(want.x));
                    end
                    if (o_y_out !== want.y) begin
                        report_mismatch("y_out", 32'(o_y_out), 32'(want.y));
                    end
                    if (o_button_a_out !== want.btn_a) begin
                        report_mismatch("button_a_out", 32'(o_button_a_out),
                            32'(want.btn_a));
                    end
                    if (o_button_b_out !== want.btn_b) begin
                        report_mismatch("button_b_out", 32'(o_button_b_out),
                            32'(want.btn_b));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_xy.push_back(calibrate_and_map(offered_req));
                cmd_count[offered_req.cmd]++;
                req_accepted++;
            end
        end
    end

    // Register writes happen only while the block is idle, so the shadow copy
    // can be updated at the same moment the write is driven.
    task automatic write_reg(t_reg idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        case (idx)
            REG_VALID_LOW:   cfg_valid_low   = value[ADC_W-1:0];
            REG_VALID_HIGH:  cfg_valid_high  = value[ADC_W-1:0];
            REG_DEFAULT_MID: cfg_default_mid = value[ADC_W-1:0];
            REG_OUT_MIN:     cfg_out_min     = value[OUT_W-1:0];
            REG_OUT_MID:     cfg_out_mid     = value[OUT_W-1:0];
            REG_OUT_MAX:     cfg_out_max     = value[OUT_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every queued request accepted and every predicted report received.
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (req_q.size() != 0 || req_accepted != req_sent || expected_xy.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Drain, pick the idle pattern and load all six registers.
    task automatic begin_phase(t_pace p, int unsigned vl, int unsigned vh, int unsigned dm,
            int unsigned omin, int unsigned omid, int unsigned omax);
        wait_for_drain();
        @(posedge i_clk);
        pace = p;
        write_reg(REG_VALID_LOW, vl);
        write_reg(REG_VALID_HIGH, vh);
        write_reg(REG_DEFAULT_MID, dm);
        write_reg(REG_OUT_MIN, omin);
        write_reg(REG_OUT_MID, omid);
        write_reg(REG_OUT_MAX, omax);
        settings_run++;
    endtask

    function automatic t_joy_req rand_req(t_cmd c);
        t_joy_req r;
        r.cmd   = c;
        r.x     = ADC_W'($urandom);
        r.y     = ADC_W'($urandom);
        r.btn_a = 1'($urandom);
        r.btn_b = 1'($urandom);
        r.axis  = 1'($urandom);
        r.lmin  = LOAD_BITS'($urandom);
        r.lmid  = LOAD_BITS'($urandom);
        r.lmax  = LOAD_BITS'($urandom);
        return r;
    endfunction

    function automatic t_joy_req directed_req(t_cmd c, int x, int y, int ax,
            int lmin, int lmid, int lmax);
        t_joy_req r;
        r      = rand_req(c);
        r.x    = ADC_W'(x);
        r.y    = ADC_W'(y);
        r.axis = ax[0];
        r.lmin = LOAD_BITS'(lmin);
        r.lmid = LOAD_BITS'(lmid);
        r.lmax = LOAD_BITS'(lmax);
        return r;
    endfunction

    // Samples lean toward the rails so clamping gets plenty of traffic.
    function automatic logic [ADC_W-1:0] pick_sample();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return ADC_W'(ADC_TOP);
            default: return ADC_W'($urandom_range(ADC_TOP, 0));
        endcase
    endfunction

    // Saved values on or beyond the edge of the ADC range, or random over the full field.
    function automatic logic [LOAD_BITS-1:0] pick_load();
        case ($urandom_range(3, 0))
            0:       return LOAD_BITS'($urandom_range(65535, 0));
            1:       return LOAD_BITS'(ADC_TOP);
            2:       return LOAD_BITS'(ADC_TOP + 1);
            default: return '0;
        endcase
    endfunction

    task automatic queue_req(t_joy_req r);
        req_q.push_back(r);
        reqs_queued++;
    endtask

    // Mostly realistic sessions: a calibration walk or a restore of saved
    // values followed by a run of conversions, with some loose random noise.
    task automatic make_traffic(int n);
        int       start;
        int       kind;
        t_joy_req r;
        start = reqs_queued;
        while (reqs_queued - start < n) begin
            kind = $urandom_range(9, 0);
            if (kind < 4) begin
                // Capture a rest position near the middle, then sweep the stick.
                r   = rand_req(CMD_CENTER);
                r.x = ADC_W'($urandom_range(600, 400));
                r.y = ADC_W'($urandom_range(600, 400));
                queue_req(r);
                repeat ($urandom_range(8, 2)) begin
                    r   = rand_req(CMD_TRACK);
                    r.x = pick_sample();
                    r.y = pick_sample();
                    queue_req(r);
                end
            end else if (kind < 7) begin
                // Restore both axes; now and then one saved value is bad.
                for (int ax = 0; ax < 2; ax++) begin
                    r      = rand_req(CMD_LOAD);
                    r.axis = ax[0];
                    r.lmin = LOAD_BITS'($urandom_range(450, 0));
                    r.lmid = LOAD_BITS'($urandom_range(700, 300));
                    r.lmax = LOAD_BITS'($urandom_range(ADC_TOP, 550));
                    if (chance(25)) begin
                        case ($urandom_range(2, 0))
                            0:       r.lmin = pick_load();
                            1:       r.lmid = pick_load();
                            default: r.lmax = pick_load();
                        endcase
                    end
                    queue_req(r);
                end
            end else if (kind == 7) begin
                r   = rand_req(CMD_CENTER);
                r.x = pick_sample();
                r.y = pick_sample();
                queue_req(r);
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    queue_req(rand_req(t_cmd'($urandom_range(3, 0))));
                end
            end
            if (kind < 8) begin
                repeat ($urandom_range(12, 3)) begin
                    r   = rand_req(CMD_CONVERT);
                    r.x = pick_sample();
                    r.y = pick_sample();
                    queue_req(r);
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with reset registers; calibration starts collapsed
        // at mid-scale so both halves are empty.
        pace = PACE_FREE;
        queue_req(directed_req(CMD_CONVERT, 0, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 512, 511, 1, 0, 0, 0));
        queue_req(directed_req(CMD_TRACK, 0, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_TRACK, ADC_TOP, 0, 1, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 0, 0, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, ADC_TOP, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 511, 513, 0, 0, 0, 0));
        // Center on the rails: one half of each axis becomes empty.
        queue_req(directed_req(CMD_CENTER, 0, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 0, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 700, 300, 1, 0, 0, 0));
        queue_req(directed_req(CMD_CENTER, 512, 512, 0, 0, 0, 0));
        queue_req(directed_req(CMD_LOAD, 0, 0, 0, 100, 400, 900));
        queue_req(directed_req(CMD_CONVERT, 50, 600, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 950, 400, 1, 0, 0, 0));
        // All saved values out of range, so the defaults go in.
        queue_req(directed_req(CMD_LOAD, 0, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Saved minimum above saved maximum.
        queue_req(directed_req(CMD_LOAD, 0, 0, 0, 800, 500, 200));
        queue_req(directed_req(CMD_CONVERT, 100, 0, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 900, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 500, 512, 0, 0, 0, 0));
        // Minimum above maximum with the center higher still: the clamped
        // sample lands below the minimum inside a nonempty lower half.
        queue_req(directed_req(CMD_LOAD, 0, 0, 0, 600, 900, 300));
        queue_req(directed_req(CMD_CONVERT, 500, 512, 0, 0, 0, 0));
        // Boundary of the validity window: top code valid, one past it not.
        queue_req(directed_req(CMD_LOAD, 0, 0, 1, 0, ADC_TOP, ADC_TOP + 1));
        queue_req(directed_req(CMD_CONVERT, ADC_TOP, ADC_TOP, 0, 0, 0, 0));
        queue_req(directed_req(CMD_LOAD, 0, 0, 1, 16'h8000, 16'h7FFF, 16'h0400));
        queue_req(directed_req(CMD_LOAD, 0, 0, 0, 0, 1, ADC_TOP));
        queue_req(directed_req(CMD_TRACK, 512, 512, 0, 0, 0, 0));
        queue_req(directed_req(CMD_CONVERT, 300, 800, 0, 0, 0, 0));

        // Reset values written back, then a long output hold-off while the
        // sender keeps pushing, so the block backs up into its input.
        begin_phase(PACE_FREE, 0, 1023, 512, 0, 128, 255);
        out_hold_cycles = HOLD_CYCLES;
        make_traffic(200);

        begin_phase(PACE_SENDER, 100, 900, 500, 10, 120, 240);
        make_traffic(200);

        // Inverted validity window: every restore falls back to defaults.
        begin_phase(PACE_RECEIVER, 800, 200, 300, 0, 128, 255);
        make_traffic(150);

        begin_phase(PACE_BOTH, 0, 0, 0, 0, 0, 0);
        make_traffic(150);

        begin_phase(PACE_FREE, ADC_TOP, ADC_TOP, ADC_TOP, 255, 255, 255);
        make_traffic(150);

        // Output codes out of order, which drives the interpolation negative.
        begin_phase(PACE_SENDER, 0, 1023, 512, 200, 10, 50);
        make_traffic(150);

        // Random settings; halfway through the sender waits for a full drain.
        begin_phase(PACE_RECEIVER, $urandom_range(ADC_TOP, 0), $urandom_range(ADC_TOP, 0),
            $urandom_range(ADC_TOP, 0), $urandom_range(255, 0), $urandom_range(255, 0),
            $urandom_range(255, 0));
        make_traffic(100);
        wait_for_drain();
        make_traffic(100);

        begin_phase(PACE_BOTH, $urandom_range(400, 0), $urandom_range(ADC_TOP, 600),
            $urandom_range(ADC_TOP, 0), $urandom_range(100, 0), $urandom_range(180, 80),
            $urandom_range(255, 160));
        make_traffic(200);

        begin_phase(PACE_FREE, 0, 1023, 512, 0, 128, 255);
        make_traffic(125);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_xy.size() != 0) begin
            report_mismatch("reports never delivered", 0, expected_xy.size());
        end
        $display("Checked %0d reports from %0d requests over %0d register settings.",
            results_seen, req_accepted, settings_run);
        $display("Commands: %0d convert, %0d track, %0d center, %0d load; %0d mismatches.",
            cmd_count[CMD_CONVERT], cmd_count[CMD_TRACK], cmd_count[CMD_CENTER],
            cmd_count[CMD_LOAD], mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
